// ===== design/cee_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cee_pkg: shared definitions for the exception entry unit
// Action codes, exception numbers, MSR masks and the vector table.
// ----------------------------------------------------------------------------
package cee_pkg;

   typedef enum logic [1:0] {
      ACT_POST      = 2'd0,
      ACT_WRITE_MSR = 2'd1,
      ACT_CHECK     = 2'd2
   } action_type;

   localparam int unsigned NUM_EXC = 8;
   localparam int unsigned EXC_W   = 3;
   localparam int unsigned CAUSE_W = 4;

   localparam logic [EXC_W-1:0] EXC_ISI     = 3'd0;
   localparam logic [EXC_W-1:0] EXC_PROGRAM = 3'd1;
   localparam logic [EXC_W-1:0] EXC_EXT     = 3'd6;
   localparam logic [EXC_W-1:0] EXC_DEC     = 3'd7;

   // exceptions that are checked ahead of the EE gate
   localparam int unsigned NUM_SYNC_EXC = 6;

   localparam logic [CAUSE_W-1:0] CAUSE_NONE = 4'd0;

   localparam logic [31:0] SAVE_MASK  = 32'h87C0_FFFF;
   localparam logic [31:0] CLEAR_MASK = 32'h0004_EF36;
   localparam logic [31:0] ISI_FLAG   = 32'h4000_0000;
   localparam logic [31:0] TRAP_FLAG  = 32'h0004_0000;
   localparam int unsigned EE_BIT     = 15;
   localparam int unsigned ILE_BIT    = 16;
   localparam int unsigned LE_BIT     = 0;

   // set: SRR0 takes npc, clear: SRR0 takes pc
   localparam logic [NUM_EXC-1:0] USE_NPC = 8'b1100_0101;

   typedef struct packed {
      logic                 taken;
      logic [CAUSE_W-1:0]   cause;
      logic [31:0]          next_fetch;
      logic [31:0]          saved_pc;
      logic [31:0]          saved_msr;
      logic [31:0]          machine_state;
      logic [NUM_EXC-1:0]   pending_now;
   } result_type;

   function automatic logic [31:0] exc_vector(input logic [EXC_W-1:0] idx);
      logic [31:0] vec;
      case (idx)
         3'd0:    vec = 32'h8000_0400;
         3'd1:    vec = 32'h8000_0700;
         3'd2:    vec = 32'h8000_0C00;
         3'd3:    vec = 32'h8000_0800;
         3'd4:    vec = 32'h8000_0300;
         3'd5:    vec = 32'h8000_0600;
         3'd6:    vec = 32'h8000_0500;
         3'd7:    vec = 32'h8000_0900;
         default: vec = 32'h8000_0400;
      endcase
      return vec;
   endfunction

endpackage

// ===== design/cpu_exception_entry.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu_exception_entry: exception entry unit
// Keeps the pending exception set, MSR, SRR0 and SRR1 and performs the
// architectural exception entry at instruction boundaries.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_*): one item per transfer. req_action selects
//   posting exception bits (req_raise_bits), writing MSR (req_msr_value) or
//   an instruction-boundary check with req_pc and req_npc.
//   Response channel (rsp_*): exactly one response per request, in order.
//   It reports whether an exception was entered, its cause, the next fetch
//   address and the SRR0, SRR1, MSR and pending bits after the item.
// Timing:
//   A request is held in the input register; the entry logic then
//   updates the state and loads the response register as the item
//   advances. Throughput is one item per cycle while rsp_ready is high,
//   set by the combinational priority select and state update.
// Reset:
//   Pending set, MSR, SRR0 and SRR1 clear to zero; both stages empty.
// Backpressure:
//   When rsp_ready is low the response holds; one more request can still
//   enter the input register, after which req_ready drops.
// ----------------------------------------------------------------------------
module cpu_exception_entry (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_action,
   input  logic [7:0]                        req_raise_bits,
   input  logic [31:0]                       req_msr_value,
   input  logic [31:0]                       req_pc,
   input  logic [31:0]                       req_npc,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_taken,
   output logic [cee_pkg::CAUSE_W-1:0]       rsp_cause,
   output logic [31:0]                       rsp_next_fetch,
   output logic [31:0]                       rsp_saved_pc,
   output logic [31:0]                       rsp_saved_msr,
   output logic [31:0]                       rsp_machine_state,
   output logic [cee_pkg::NUM_EXC-1:0]       rsp_pending_now
);

   // input stage
   logic                            in_vld_ff;
   logic [1:0]                      action_ff;
   logic [cee_pkg::NUM_EXC-1:0]     raise_ff;
   logic [31:0]                     msr_value_ff;
   logic [31:0]                     pc_ff;
   logic [31:0]                     npc_ff;

   // architectural state
   logic [cee_pkg::NUM_EXC-1:0]     pending_ff, pending_in;
   logic [31:0]                     msr_ff, msr_in;
   logic [31:0]                     srr0_ff, srr0_in;
   logic [31:0]                     srr1_ff, srr1_in;

   // output stage
   logic                            out_vld_ff;
   cee_pkg::result_type             res_ff, res_in;

   logic                            advance;
   logic                            hit;
   logic [cee_pkg::EXC_W-1:0]       exc_idx;
   logic [31:0]                     extra;
   logic [31:0]                     msr_le;

   assign advance   = in_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ready) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         action_ff    <= req_action;
         raise_ff     <= req_raise_bits;
         msr_value_ff <= req_msr_value;
         pc_ff        <= req_pc;
         npc_ff       <= req_npc;
      end
   end

   // priority select: synchronous causes first, then EE-gated ones
   always_comb begin
      hit     = 1'b0;
      exc_idx = cee_pkg::EXC_ISI;
      for (int i = cee_pkg::NUM_SYNC_EXC - 1; i >= 0; i--) begin
         if (pending_ff[i]) begin
            hit     = 1'b1;
            exc_idx = cee_pkg::EXC_W'(i);
         end
      end
      if (!hit && msr_ff[cee_pkg::EE_BIT]) begin
         if (pending_ff[cee_pkg::EXC_EXT]) begin
            hit     = 1'b1;
            exc_idx = cee_pkg::EXC_EXT;
         end else if (pending_ff[cee_pkg::EXC_DEC]) begin
            hit     = 1'b1;
            exc_idx = cee_pkg::EXC_DEC;
         end
      end
   end

   always_comb begin
      case (exc_idx)
         cee_pkg::EXC_ISI:     extra = cee_pkg::ISI_FLAG;
         cee_pkg::EXC_PROGRAM: extra = cee_pkg::TRAP_FLAG;
         default:              extra = 32'd0;
      endcase
      msr_le = msr_ff;
      msr_le[cee_pkg::LE_BIT] = msr_ff[cee_pkg::LE_BIT] | msr_ff[cee_pkg::ILE_BIT];
   end

   always_comb begin
      pending_in        = pending_ff;
      msr_in            = msr_ff;
      srr0_in           = srr0_ff;
      srr1_in           = srr1_ff;
      res_in.taken      = 1'b0;
      res_in.cause      = cee_pkg::CAUSE_NONE;
      res_in.next_fetch = npc_ff;
      case (action_ff)
         cee_pkg::ACT_POST: begin
            pending_in = pending_ff | raise_ff;
         end
         cee_pkg::ACT_WRITE_MSR: begin
            msr_in = msr_value_ff;
         end
         cee_pkg::ACT_CHECK: begin
            if (hit) begin
               srr0_in = cee_pkg::USE_NPC[exc_idx] ? npc_ff : pc_ff;
               srr1_in = (msr_ff & cee_pkg::SAVE_MASK) | extra;
               msr_in  = msr_le & ~cee_pkg::CLEAR_MASK;
               pending_in[exc_idx] = 1'b0;
               res_in.taken      = 1'b1;
               res_in.cause      = {1'b0, exc_idx} + cee_pkg::CAUSE_W'(1);
               res_in.next_fetch = cee_pkg::exc_vector(exc_idx);
            end
         end
         default: begin
            // unused action: no state change
         end
      endcase
      res_in.saved_pc      = srr0_in;
      res_in.saved_msr     = srr1_in;
      res_in.machine_state = msr_in;
      res_in.pending_now   = pending_in;
   end

   // commit state and load the response as the item advances
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         msr_ff     <= '0;
         srr0_ff    <= '0;
         srr1_ff    <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         if (advance) begin
            pending_ff <= pending_in;
            msr_ff     <= msr_in;
            srr0_ff    <= srr0_in;
            srr1_ff    <= srr1_in;
            out_vld_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid         = out_vld_ff;
   assign rsp_taken         = res_ff.taken;
   assign rsp_cause         = res_ff.cause;
   assign rsp_next_fetch    = res_ff.next_fetch;
   assign rsp_saved_pc      = res_ff.saved_pc;
   assign rsp_saved_msr     = res_ff.saved_msr;
   assign rsp_machine_state = res_ff.machine_state;
   assign rsp_pending_now   = res_ff.pending_now;

endmodule
